// ----- sv/dcl_pkg.sv -----
package dcl_pkg;

    localparam int LANES      = 4;
    localparam int LANE_W     = 2;
    localparam int DIMS       = 4;
    localparam int DIMS_W     = 3;
    localparam int COORD_BITS = 16;
    localparam int SUM_W      = 2 * COORD_BITS + 2;
    localparam int EPS_W      = 35;
    localparam int MINP_W     = 11;
    localparam int CNT_OUT_W  = 11;
    localparam int ID_W       = 10;
    localparam int IDX_IN_W   = 10;
    localparam int MAX_POINTS_DEF = 1024;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_RUN   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic [1:0] CFG_EPS  = 2'd0;
    localparam logic [1:0] CFG_MINP = 2'd1;
    localparam logic [1:0] CFG_DIMS = 2'd2;

    localparam logic [1:0] LK_UNVIS = 2'd0;
    localparam logic [1:0] LK_NOISE = 2'd1;
    localparam logic [1:0] LK_CLUS  = 2'd2;

    localparam logic [EPS_W-1:0]  EPS_RST  = 35'd1048576;
    localparam logic [MINP_W-1:0] MINP_RST = 11'd4;
    localparam logic [DIMS_W-1:0] DIMS_RST = 3'd2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef t_coord [DIMS-1:0] t_point;

    typedef struct packed {
        logic [1:0]      kind;
        logic            pend;
        logic [ID_W-1:0] id;
    } t_label;

    typedef struct packed {
        logic clr;
        logic valid;
        logic expand;
    } t_mctl;

    localparam t_label LBL_UNVIS = '{kind: LK_UNVIS, pend: 1'b0, id: '0};
    localparam t_label LBL_NOISE = '{kind: LK_NOISE, pend: 1'b0, id: '0};

endpackage

// ----- sv/density_clustering_labeler_core.sv -----
// Density clustering labeler. Loads and clears leave the block idle and may
// follow each other back to back; a label read holds busy while it passes
// through S_RDLBL, which registers the fetched label onto the result outputs.
// A run first rewrites the labels of the N loaded points as unvisited, row by
// row, then every neighbourhood count or expansion is a sweep over the rows
// through four distance lanes that share one row read of the banked point
// store; each unvisited seed costs one sweep, each cluster member two when it
// is core, plus a scan sweep to find the next pending member. Results appear
// for one cycle on o_strobe and cannot be held off. No memory clearing pass
// follows reset.
module density_clustering_labeler_core
    import dcl_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_action,
    input  logic signed [15:0]    i_coord_0,
    input  logic signed [15:0]    i_coord_1,
    input  logic signed [15:0]    i_coord_2,
    input  logic signed [15:0]    i_coord_3,
    input  logic [IDX_IN_W-1:0]   i_point_index,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [EPS_W-1:0]      i_cfg_wdata,
    output logic                  o_strobe,
    output logic                  o_result_kind,
    output logic [ID_W-1:0]       o_cluster_id,
    output logic                  o_is_noise,
    output logic [CNT_OUT_W-1:0]  o_cluster_count,
    output logic [CNT_OUT_W-1:0]  o_noise_count,
    output logic                  o_bad_index
);

    localparam int ROWS  = (MAX_POINTS + LANES - 1) / LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int WW    = ROW_W + LANE_W + 1;
    localparam int CW    = (WW > CNT_OUT_W) ? WW : CNT_OUT_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDLBL  = 4'd1;
    localparam logic [3:0] S_INIT   = 4'd2;
    localparam logic [3:0] S_OUTER  = 4'd3;
    localparam logic [3:0] S_OUTW   = 4'd4;
    localparam logic [3:0] S_COUNT  = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_EXPAND = 4'd7;

    logic [3:0]           r_state;
    logic [EPS_W-1:0]     r_eps;
    logic [MINP_W-1:0]    r_minp;
    logic [DIMS_W-1:0]    r_dims;
    logic [CNT_W-1:0]     r_loaded;
    logic [CNT_OUT_W-1:0] r_ncl;
    logic [CNT_OUT_W-1:0] r_nno;
    logic [CNT_W-1:0]     r_i;
    logic                 r_seed;
    t_point               r_cur;
    logic [ROW_W-1:0]     r_cur_row;
    logic [LANE_W-1:0]    r_cur_lane;
    logic                 r_rd_bad;
    logic [LANE_W-1:0]    r_rd_lane;

    // sweep issue and row pipeline
    logic [ROW_W-1:0]     r_sw_row;
    logic                 r_sw_go;
    logic                 r_v1, r_c1, r_v2, r_v3, r_v4;
    logic [ROW_W-1:0]     r_row1, r_row2, r_row3, r_row4;
    logic [LANES-1:0]     r_m1, r_m2, r_m3, r_m4;
    t_label               r_lb2 [LANES];
    t_label               r_lb3 [LANES];
    t_label               r_lb4 [LANES];

    t_point               r_pt_q [LANES];
    t_label               r_lb_q [LANES];

    logic                 r_strobe, r_kind, r_noise, r_bad;
    logic [ID_W-1:0]      r_id_out;

    logic [ROW_W-1:0]     rd_row;
    logic [ROW_W-1:0]     ld_row;
    logic [LANE_W-1:0]    ld_lane;
    logic [ROW_W-1:0]     i_row;
    logic [LANE_W-1:0]    i_lane;
    logic [ROW_W-1:0]     last_row;
    logic                 not_full;
    logic                 accept;
    t_point               ld_pt;
    logic [LANES-1:0]     pt_we;
    logic [LANES-1:0]     lb_we;
    logic [ROW_W-1:0]     lb_wa;
    t_label               lb_wd [LANES];
    logic [LANES-1:0]     iss_mask;
    logic [LANES-1:0]     hit;
    logic [DIMS_W-1:0]    nd;
    logic                 f_any;
    logic [LANE_W-1:0]    f_lane;
    logic                 sw_done;
    logic                 core;
    logic                 sweep_st;
    logic                 lane_st;
    t_mctl                m_ctl;
    logic [CNT_W-1:0]     m_cnt;
    logic [LANES-1:0]     m_we;
    t_label               m_wlbl [LANES];
    t_label               lbl_i;
    t_label               lbl_rd;

    assign accept   = start && !busy;
    assign busy     = (r_state != S_IDLE);
    assign ld_row   = ROW_W'(r_loaded >> LANE_W);
    assign ld_lane  = r_loaded[LANE_W-1:0];
    assign i_row    = ROW_W'(r_i >> LANE_W);
    assign i_lane   = r_i[LANE_W-1:0];
    assign last_row = ROW_W'((CW'(r_loaded) - CW'(1)) >> LANE_W);
    assign not_full = CW'(r_loaded) < CW'(MAX_POINTS);
    assign nd       = (r_dims == '0) ? DIMS_W'(1)
                    : ((r_dims > DIMS_W'(DIMS)) ? DIMS_W'(DIMS) : r_dims);
    assign sw_done  = !r_sw_go && !r_c1 && !r_v2 && !r_v3 && !r_v4;
    assign core     = 32'(m_cnt) >= 32'(r_minp);
    assign sweep_st = (r_state == S_COUNT) || (r_state == S_EXPAND) || (r_state == S_SCAN);
    assign lane_st  = (r_state == S_COUNT) || (r_state == S_EXPAND);
    assign lbl_i    = r_lb_q[i_lane];
    assign lbl_rd   = r_lb_q[r_rd_lane];

    always_comb begin
        ld_pt[0] = i_coord_0;
        ld_pt[1] = i_coord_1;
        ld_pt[2] = i_coord_2;
        ld_pt[3] = i_coord_3;
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            iss_mask[l] = CW'({r_sw_row, LANE_W'(l)}) < CW'(r_loaded);
        end
    end

    // first pending member in the row just read
    always_comb begin
        f_any  = 1'b0;
        f_lane = '0;
        for (int l = LANES - 1; l >= 0; l--) begin
            if (r_v1 && r_m1[l] && r_lb_q[l].pend) begin
                f_any  = 1'b1;
                f_lane = LANE_W'(l);
            end
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:  rd_row = ROW_W'(i_point_index >> LANE_W);
            S_OUTER: rd_row = i_row;
            default: rd_row = r_sw_row;
        endcase
    end

    always_comb begin
        pt_we = '0;
        lb_we = '0;
        lb_wa = r_sw_row;
        for (int l = 0; l < LANES; l++) begin
            lb_wd[l] = LBL_UNVIS;
        end
        case (r_state)
            S_IDLE: begin
                if (accept && i_action == ACT_LOAD && not_full) begin
                    pt_we[ld_lane] = 1'b1;
                    lb_we[ld_lane] = 1'b1;
                    lb_wa          = ld_row;
                end
            end
            S_INIT: begin
                lb_we = '1;
            end
            S_COUNT: begin
                if (sw_done && r_seed) begin
                    lb_we[r_cur_lane] = 1'b1;
                    lb_wa             = r_cur_row;
                    lb_wd[r_cur_lane] = core
                        ? '{kind: LK_CLUS, pend: 1'b1, id: r_ncl[ID_W-1:0]}
                        : LBL_NOISE;
                end
            end
            S_SCAN: begin
                if (f_any) begin
                    lb_we[f_lane] = 1'b1;
                    lb_wa         = r_row1;
                    lb_wd[f_lane] = '{kind: LK_CLUS, pend: 1'b0, id: r_ncl[ID_W-1:0]};
                end
            end
            S_EXPAND: begin
                lb_we = m_we;
                lb_wa = r_row4;
                for (int l = 0; l < LANES; l++) begin
                    lb_wd[l] = m_wlbl[l];
                end
            end
            default: ;
        endcase
    end

    for (genvar l = 0; l < LANES; l++) begin : g_bank
        t_point pmem [ROWS];
        t_label lmem [ROWS];

        always_ff @(posedge i_clk) begin
            if (pt_we[l]) begin
                pmem[ld_row] <= ld_pt;
            end
            if (lb_we[l]) begin
                lmem[lb_wa] <= lb_wd[l];
            end
            r_pt_q[l] <= pmem[rd_row];
            r_lb_q[l] <= lmem[rd_row];
        end

        dcl_lane u_lane (
            .i_clk  (i_clk),
            .i_cur  (r_cur),
            .i_cand (r_pt_q[l]),
            .i_nd   (nd),
            .i_eps  (r_eps),
            .o_hit  (hit[l])
        );
    end

    always_comb begin
        m_ctl.clr    = ((r_state == S_OUTW) && lbl_i.kind == LK_UNVIS)
                    || ((r_state == S_SCAN) && f_any);
        m_ctl.valid  = r_v4;
        m_ctl.expand = (r_state == S_EXPAND);
    end

    dcl_merge #(
        .CNT_W (CNT_W)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (m_ctl),
        .i_hit   (hit),
        .i_mask  (r_m4),
        .i_lbl   (r_lb4),
        .i_id    (r_ncl[ID_W-1:0]),
        .o_cnt   (m_cnt),
        .o_we    (m_we),
        .o_wlbl  (m_wlbl)
    );

    // row and label words travel alongside the lane stages
    always_ff @(posedge i_clk) begin
        r_row1 <= r_sw_row;
        r_m1   <= iss_mask;
        r_row2 <= r_row1;
        r_row3 <= r_row2;
        r_row4 <= r_row3;
        r_m2   <= r_m1;
        r_m3   <= r_m2;
        r_m4   <= r_m3;
        for (int l = 0; l < LANES; l++) begin
            r_lb2[l] <= r_lb_q[l];
            r_lb3[l] <= r_lb2[l];
            r_lb4[l] <= r_lb3[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_eps    <= EPS_RST;
            r_minp   <= MINP_RST;
            r_dims   <= DIMS_RST;
            r_loaded <= '0;
            r_ncl    <= '0;
            r_nno    <= '0;
            r_i      <= '0;
            r_seed   <= 1'b0;
            r_sw_row <= '0;
            r_sw_go  <= 1'b0;
            r_v1     <= 1'b0;
            r_c1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_strobe <= 1'b0;
            r_kind   <= 1'b0;
            r_noise  <= 1'b0;
            r_bad    <= 1'b0;
            r_id_out <= '0;
            r_rd_bad <= 1'b0;
            r_rd_lane <= '0;
            r_cur_row <= '0;
            r_cur_lane <= '0;
        end else begin
            r_strobe <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_EPS:  r_eps  <= i_cfg_wdata;
                    CFG_MINP: r_minp <= i_cfg_wdata[MINP_W-1:0];
                    CFG_DIMS: r_dims <= i_cfg_wdata[DIMS_W-1:0];
                    default:  ;
                endcase
            end

            r_v1 <= r_sw_go && sweep_st;
            r_c1 <= r_sw_go && lane_st;
            r_v2 <= r_c1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;

            if (r_sw_go) begin
                if (r_sw_row == last_row) begin
                    r_sw_go <= 1'b0;
                end else begin
                    r_sw_row <= r_sw_row + 1'b1;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_action)
                            ACT_LOAD: begin
                                if (not_full) begin
                                    r_loaded <= r_loaded + 1'b1;
                                end
                            end
                            ACT_CLEAR: begin
                                r_loaded <= '0;
                                r_ncl    <= '0;
                                r_nno    <= '0;
                            end
                            ACT_RUN: begin
                                r_ncl <= '0;
                                r_nno <= '0;
                                r_i   <= '0;
                                if (r_loaded == '0) begin
                                    r_state <= S_OUTER;
                                end else begin
                                    r_state  <= S_INIT;
                                    r_sw_row <= '0;
                                    r_sw_go  <= 1'b1;
                                end
                            end
                            ACT_READ: begin
                                r_rd_bad  <= CW'(i_point_index) >= CW'(r_loaded);
                                r_rd_lane <= i_point_index[LANE_W-1:0];
                                r_state   <= S_RDLBL;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RDLBL: begin
                    r_strobe <= 1'b1;
                    r_kind   <= 1'b1;
                    r_bad    <= r_rd_bad;
                    r_noise  <= !r_rd_bad && lbl_rd.kind != LK_CLUS;
                    r_id_out <= (!r_rd_bad && lbl_rd.kind == LK_CLUS) ? lbl_rd.id : '0;
                    r_state  <= S_IDLE;
                end
                S_INIT: begin
                    if (r_sw_row == last_row) begin
                        r_state <= S_OUTER;
                    end
                end
                S_OUTER: begin
                    if (CW'(r_i) >= CW'(r_loaded)) begin
                        r_strobe <= 1'b1;
                        r_kind   <= 1'b0;
                        r_bad    <= 1'b0;
                        r_noise  <= 1'b0;
                        r_id_out <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_OUTW;
                    end
                end
                S_OUTW: begin
                    if (lbl_i.kind != LK_UNVIS) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_OUTER;
                    end else begin
                        r_cur      <= r_pt_q[i_lane];
                        r_cur_row  <= i_row;
                        r_cur_lane <= i_lane;
                        r_seed     <= 1'b1;
                        r_sw_row   <= '0;
                        r_sw_go    <= 1'b1;
                        r_state    <= S_COUNT;
                    end
                end
                S_COUNT: begin
                    if (sw_done) begin
                        r_sw_row <= '0;
                        if (r_seed && !core) begin
                            r_nno   <= r_nno + 1'b1;
                            r_i     <= r_i + 1'b1;
                            r_state <= S_OUTER;
                        end else if (!r_seed && core) begin
                            r_sw_go <= 1'b1;
                            r_state <= S_EXPAND;
                        end else begin
                            r_sw_go <= 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (f_any) begin
                        r_cur      <= r_pt_q[f_lane];
                        r_cur_row  <= r_row1;
                        r_cur_lane <= f_lane;
                        r_seed     <= 1'b0;
                        r_sw_row   <= '0;
                        r_sw_go    <= 1'b1;
                        r_v1       <= 1'b0;
                        r_state    <= S_COUNT;
                    end else if (!r_sw_go && !r_v1) begin
                        // no member left pending: the cluster is complete
                        r_ncl   <= r_ncl + 1'b1;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_OUTER;
                    end
                end
                S_EXPAND: begin
                    if (sw_done) begin
                        r_sw_row <= '0;
                        r_sw_go  <= 1'b1;
                        r_state  <= S_SCAN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe        = r_strobe;
    assign o_result_kind   = r_kind;
    assign o_cluster_id    = r_id_out;
    assign o_is_noise      = r_noise;
    assign o_cluster_count = r_ncl;
    assign o_noise_count   = r_nno;
    assign o_bad_index     = r_bad;

endmodule

// ----- sv/dcl_lane.sv -----
module dcl_lane
    import dcl_pkg::*;
(
    input  logic              i_clk,
    input  t_point            i_cur,
    input  t_point            i_cand,
    input  logic [DIMS_W-1:0] i_nd,
    input  logic [EPS_W-1:0]  i_eps,
    output logic              o_hit
);

    logic [COORD_BITS-1:0]   n_dif [DIMS];
    logic [COORD_BITS-1:0]   r_dif [DIMS];
    logic [2*COORD_BITS-1:0] r_sq  [DIMS];
    logic [SUM_W-1:0]        n_sum;
    logic                    r_hit;

    // absolute difference per coordinate, unused coordinates forced to zero
    always_comb begin
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] a;
        for (int k = 0; k < DIMS; k++) begin
            d = {i_cur[k][COORD_BITS-1], i_cur[k]} - {i_cand[k][COORD_BITS-1], i_cand[k]};
            a = d[COORD_BITS] ? (~d + 1'b1) : d;
            n_dif[k] = (DIMS_W'(k) < i_nd) ? a[COORD_BITS-1:0] : '0;
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < DIMS; k++) begin
            n_sum = n_sum + SUM_W'(r_sq[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIMS; k++) begin
            r_dif[k] <= n_dif[k];
            r_sq[k]  <= {{COORD_BITS{1'b0}}, r_dif[k]} * {{COORD_BITS{1'b0}}, r_dif[k]};
        end
        r_hit <= (EPS_W'(n_sum) <= i_eps);
    end

    assign o_hit = r_hit;

endmodule

// ----- sv/dcl_merge.sv -----
module dcl_merge
    import dcl_pkg::*;
#(
    parameter int CNT_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mctl            i_ctl,
    input  logic [LANES-1:0] i_hit,
    input  logic [LANES-1:0] i_mask,
    input  t_label           i_lbl [LANES],
    input  logic [ID_W-1:0]  i_id,
    output logic [CNT_W-1:0] o_cnt,
    output logic [LANES-1:0] o_we,
    output t_label           o_wlbl [LANES]
);

    logic [CNT_W-1:0] r_cnt;
    logic [LANE_W:0]  n_pop;
    logic [LANES-1:0] near;

    assign near = i_hit & i_mask & {LANES{i_ctl.valid}};

    always_comb begin
        n_pop = '0;
        for (int l = 0; l < LANES; l++) begin
            n_pop = n_pop + (LANE_W + 1)'(near[l]);
        end
    end

    // unvisited neighbours join and go pending; noise neighbours become border
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_we[l] = i_ctl.expand && near[l]
                      && (i_lbl[l].kind == LK_UNVIS || i_lbl[l].kind == LK_NOISE);
            o_wlbl[l] = '{kind: LK_CLUS, pend: (i_lbl[l].kind == LK_UNVIS), id: i_id};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.clr) begin
            r_cnt <= '0;
        end else if (i_ctl.valid && !i_ctl.expand) begin
            r_cnt <= r_cnt + CNT_W'(n_pop);
        end
    end

    assign o_cnt = r_cnt;

endmodule

// ----- sv/dcl_checker.sv -----
module dcl_checker
    import dcl_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 busy,
    input logic                 o_strobe,
    input logic                 o_result_kind,
    input logic [ID_W-1:0]      o_cluster_id,
    input logic                 o_is_noise,
    input logic                 o_bad_index
);

    // a word only follows a command that held busy
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result word without preceding busy");

    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two result words in a row");

    a_summary_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result_kind) |-> (o_cluster_id == '0 && !o_is_noise && !o_bad_index))
        else $error("run summary carries label fields");

    a_label_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_bad_index || o_is_noise)) |-> (o_cluster_id == '0))
        else $error("cluster id set on noise or bad index");

    a_bad_not_noise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_bad_index) |-> !o_is_noise)
        else $error("bad index also flagged noise");

endmodule

bind density_clustering_labeler_core dcl_checker u_dcl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_result_kind (o_result_kind),
    .o_cluster_id  (o_cluster_id),
    .o_is_noise    (o_is_noise),
    .o_bad_index   (o_bad_index)
);

// ----- dv/density_clustering_labeler_core_tb.sv -----
`timescale 1ns / 100ps

module density_clustering_labeler_core_tb;
    import dcl_pkg::*;

    localparam int CAPACITY   = MAX_POINTS_DEF;
    localparam int IDLE_LIMIT = 200000;
    localparam int ITEM_GOAL  = 1850;
    localparam int UNVISITED  = -1;
    localparam int NOISE      = -2;

    typedef struct packed {
        logic                 kind;
        logic [ID_W-1:0]      id;
        logic                 noise;
        logic [CNT_OUT_W-1:0] clusters;
        logic [CNT_OUT_W-1:0] noise_pts;
        logic                 bad;
    } label_word_t;

    // Label predictor plus queue of answers still owed by the block
    class cluster_label_board;
        int                pt[CAPACITY][DIMS];
        int                lbl[CAPACITY];
        int                loaded;
        int                n_clusters;
        int                n_noise;
        logic [EPS_W-1:0]  eps;
        logic [MINP_W-1:0] minp;
        logic [DIMS_W-1:0] dims;
        label_word_t       owed[$];
        int                errors;

        function new();
            foreach (lbl[i]) lbl[i] = UNVISITED;
            loaded = 0;
            n_clusters = 0;
            n_noise = 0;
            eps = EPS_RST;
            minp = MINP_RST;
            dims = DIMS_RST;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [EPS_W-1:0] data);
            case (idx)
                CFG_EPS:  eps = data;
                CFG_MINP: minp = data[MINP_W-1:0];
                CFG_DIMS: dims = data[DIMS_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned sq_gap(int a, int b);
            int nd;
            longint unsigned sum;
            longint unsigned d;
            nd = (dims == 0) ? 1 : ((dims > DIMS) ? DIMS : int'(dims));
            sum = 0;
            for (int k = 0; k < nd; k++) begin
                d = (pt[a][k] >= pt[b][k]) ? pt[a][k] - pt[b][k] : pt[b][k] - pt[a][k];
                sum += d * d;
            end
            return sum;
        endfunction

        function bit is_near(int a, int b);
            return sq_gap(a, b) <= {29'd0, eps};
        endfunction

        function bit is_core(int p);
            int c;
            c = 0;
            for (int j = 0; j < loaded; j++) if (is_near(p, j)) c++;
            return c >= int'(minp);
        endfunction

        function void label_all();
            int stk[$];
            int cur;
            n_clusters = 0;
            n_noise = 0;
            for (int i = 0; i < loaded; i++) lbl[i] = UNVISITED;
            for (int i = 0; i < loaded; i++) begin
                if (lbl[i] != UNVISITED) continue;
                if (!is_core(i)) begin
                    lbl[i] = NOISE;
                    n_noise++;
                    continue;
                end
                lbl[i] = n_clusters;
                stk.push_back(i);
                while (stk.size() > 0) begin
                    cur = stk.pop_back();
                    if (!is_core(cur)) continue;
                    for (int j = 0; j < loaded; j++) begin
                        if (!is_near(cur, j)) continue;
                        if (lbl[j] == UNVISITED) begin
                            lbl[j] = n_clusters;
                            stk.push_back(j);
                        end else if (lbl[j] == NOISE) begin
                            lbl[j] = n_clusters;
                        end
                    end
                end
                n_clusters++;
            end
        endfunction

        function void note_word(logic [1:0] act, t_coord c0, t_coord c1, t_coord c2,
                                t_coord c3, logic [IDX_IN_W-1:0] idx);
            label_word_t w;
            w = '0;
            case (act)
                ACT_LOAD: begin
                    if (loaded < CAPACITY) begin
                        pt[loaded][0] = c0;
                        pt[loaded][1] = c1;
                        pt[loaded][2] = c2;
                        pt[loaded][3] = c3;
                        lbl[loaded] = UNVISITED;
                        loaded++;
                    end
                end
                ACT_CLEAR: begin
                    foreach (lbl[i]) lbl[i] = UNVISITED;
                    loaded = 0;
                    n_clusters = 0;
                    n_noise = 0;
                end
                ACT_RUN: begin
                    label_all();
                    w.clusters = n_clusters[CNT_OUT_W-1:0];
                    w.noise_pts = n_noise[CNT_OUT_W-1:0];
                    owed.push_back(w);
                end
                default: begin
                    w.kind = 1'b1;
                    w.clusters = n_clusters[CNT_OUT_W-1:0];
                    w.noise_pts = n_noise[CNT_OUT_W-1:0];
                    if (int'(idx) >= loaded) w.bad = 1'b1;
                    else if (lbl[idx] < 0) w.noise = 1'b1;
                    else w.id = lbl[idx][ID_W-1:0];
                    owed.push_back(w);
                end
            endcase
        endfunction

        function void check_word(label_word_t got);
            label_word_t want;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %p", got);
                return;
            end
            want = owed.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           i_action = ACT_LOAD;
    t_coord               i_coord_0 = '0;
    t_coord               i_coord_1 = '0;
    t_coord               i_coord_2 = '0;
    t_coord               i_coord_3 = '0;
    logic [IDX_IN_W-1:0]  i_point_index = '0;
    logic                 i_cfg_we = 1'b0;
    logic [1:0]           i_cfg_idx = CFG_EPS;
    logic [EPS_W-1:0]     i_cfg_wdata = '0;
    logic                 o_strobe;
    logic                 o_result_kind;
    logic [ID_W-1:0]      o_cluster_id;
    logic                 o_is_noise;
    logic [CNT_OUT_W-1:0] o_cluster_count;
    logic [CNT_OUT_W-1:0] o_noise_count;
    logic                 o_bad_index;

    cluster_label_board board = new();
    int burst_left = 0;
    int words_sent = 0;
    int idle_cycles = 0;
    int centre[4][DIMS];
    int spread;

    density_clustering_labeler_core uut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            board.check_word('{o_result_kind, o_cluster_id, o_is_noise,
                               o_cluster_count, o_noise_count, o_bad_index});
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || i_cfg_we || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_word(logic [1:0] act, t_coord c0, t_coord c1, t_coord c2,
                             t_coord c3, logic [IDX_IN_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        i_action <= act;
        i_coord_0 <= c0;
        i_coord_1 <= c1;
        i_coord_2 <= c2;
        i_coord_3 <= c3;
        i_point_index <= idx;
        do @(posedge i_clk); while (busy);
        board.note_word(act, c0, c1, c2, c3, idx);
        words_sent++;
    endtask

    task automatic load(t_coord c0, t_coord c1, t_coord c2, t_coord c3);
        send_word(ACT_LOAD, c0, c1, c2, c3, IDX_IN_W'($urandom_range(0, 1023)));
    endtask

    task automatic cmd(logic [1:0] act, logic [IDX_IN_W-1:0] idx);
        send_word(act, t_coord'($urandom_range(0, 65535)), t_coord'($urandom_range(0, 65535)),
                  t_coord'($urandom_range(0, 65535)), t_coord'($urandom_range(0, 65535)), idx);
    endtask

    // only touch the registers once every owed word is back
    task automatic write_regs(logic [EPS_W-1:0] eps, logic [MINP_W-1:0] minp,
                              logic [DIMS_W-1:0] dims);
        logic [EPS_W-1:0] vals[3];
        logic [1:0]       idxs[3];
        vals = '{eps, {24'd0, minp}, {32'd0, dims}};
        idxs = '{CFG_EPS, CFG_MINP, CFG_DIMS};
        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        for (int r = 0; r < 3; r++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idxs[r];
            i_cfg_wdata <= vals[r];
            @(posedge i_clk);
            board.set_reg(idxs[r], vals[r]);
        end
        i_cfg_we <= 1'b0;
        burst_left = 0;
    endtask

    function automatic t_coord near_coord(int c);
        int v;
        v = c + $urandom_range(0, 2 * spread) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return t_coord'(v);
    endfunction

    task automatic load_clustered(int n_centres);
        int c;
        if ($urandom_range(0, 7) == 0) begin
            load(t_coord'($urandom_range(0, 65535)), t_coord'($urandom_range(0, 65535)),
                 t_coord'($urandom_range(0, 65535)), t_coord'($urandom_range(0, 65535)));
        end else begin
            c = $urandom_range(0, n_centres - 1);
            load(near_coord(centre[c][0]), near_coord(centre[c][1]),
                 near_coord(centre[c][2]), near_coord(centre[c][3]));
        end
    endtask

    task automatic random_phase(int ph);
        int n;
        int n_centres;
        int reads;
        longint unsigned e;
        spread = $urandom_range(1, 3000);
        n_centres = $urandom_range(1, 4);
        foreach (centre[i, k]) centre[i][k] = $urandom_range(0, 60000) - 30000;
        e = longint'(spread) * spread * $urandom_range(1, 6);
        case (ph % 7)
            0: write_regs('0, 11'd1, 3'd1);
            1: write_regs(35'h4_0000_0000, 11'd2047, 3'd7);
            2: write_regs(35'h4_0000_0000, 11'd0, 3'd4);
            3: write_regs(EPS_W'({$urandom, $urandom}), 11'd1024, 3'd0);
            4: write_regs(35'h7_FFFF_FFFF, MINP_W'($urandom_range(1, 8)), 3'd5);
            default: write_regs(e[EPS_W-1:0], MINP_W'($urandom_range(1, 6)),
                                DIMS_W'($urandom_range(0, 7)));
        endcase
        cmd(ACT_CLEAR, IDX_IN_W'($urandom_range(0, 1023)));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 48) : $urandom_range(1, 24);
        for (int i = 0; i < n; i++) load_clustered(n_centres);
        for (int pass = 0; pass < 2; pass++) begin
            cmd(ACT_RUN, IDX_IN_W'($urandom_range(0, 1023)));
            reads = $urandom_range(4, 14);
            for (int r = 0; r < reads; r++) begin
                if ($urandom_range(0, 5) == 0) cmd(ACT_READ, IDX_IN_W'($urandom_range(0, 1023)));
                else cmd(ACT_READ, IDX_IN_W'($urandom_range(0, n + 1)));
                // occasional noise word of any kind
                if ($urandom_range(0, 19) == 0)
                    cmd(2'($urandom_range(0, 3)), IDX_IN_W'($urandom_range(0, 1023)));
            end
            if ($urandom_range(0, 1) == 0) break;
            for (int i = 0; i < $urandom_range(1, 4); i++) load_clustered(n_centres);
            cmd(ACT_READ, IDX_IN_W'(board.loaded - 1));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, extremes, unvisited reads, clear
        cmd(ACT_READ, 10'd0);
        cmd(ACT_READ, 10'd1023);
        cmd(ACT_RUN, 10'd0);
        load(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        load(16'sd10, 16'sd10, -16'sd3, 16'sd1);
        load(-16'sd10, 16'sd5, 16'sd7, 16'sd2);
        load(16'sd3, -16'sd7, 16'sd0, -16'sd1);
        load(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        load(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        cmd(ACT_READ, 10'd0);
        cmd(ACT_RUN, 10'd0);
        for (int i = 0; i < 7; i++) cmd(ACT_READ, IDX_IN_W'(i));
        load(16'sd1, 16'sd1, 16'sd1, 16'sd1);
        cmd(ACT_READ, 10'd6);
        cmd(ACT_CLEAR, 10'd0);
        cmd(ACT_READ, 10'd0);
        cmd(ACT_RUN, 10'd0);

        // fill past capacity; no run on the full store
        write_regs(EPS_RST, MINP_RST, DIMS_RST);
        for (int i = 0; i < CAPACITY + 6; i++)
            load(t_coord'($urandom_range(0, 65535)), t_coord'($urandom_range(0, 65535)),
                 t_coord'($urandom_range(0, 65535)), t_coord'($urandom_range(0, 65535)));
        cmd(ACT_READ, 10'd1023);
        cmd(ACT_READ, 10'd512);
        cmd(ACT_READ, 10'd0);
        cmd(ACT_CLEAR, 10'd0);

        for (int ph = 0; words_sent < ITEM_GOAL; ph++) random_phase(ph);

        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
